FILE: design/ttp_pkg.sv
package ttp_pkg;

  localparam int unsigned MaxStations = 1024;
  localparam int unsigned CountW  = 11;
  localparam int unsigned IdxW    = 10;
  localparam int unsigned ThickW  = 32;
  localparam int unsigned SafeW   = 17;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 32;
  localparam int unsigned PosW    = 13;
  localparam int unsigned DivNumW = ThickW + IdxW;
  localparam int unsigned DivBitsPerStage = 2;
  localparam int unsigned DivStages = ThickW / DivBitsPerStage;
  localparam logic [SafeW-1:0] SafetyOne = 17'h10000;

  typedef enum logic [2:0] {
    ERR_OK     = 3'd0,
    ERR_COUNT  = 3'd1,
    ERR_RANGE  = 3'd2,
    ERR_DESIGN = 3'd3,
    ERR_SAFETY = 3'd4,
    ERR_MIN    = 3'd5,
    ERR_INDEX  = 3'd6
  } err_e;

  typedef enum logic [2:0] {
    REG_STATION_COUNT    = 3'd0,
    REG_REPAIR_START     = 3'd1,
    REG_REPAIR_END       = 3'd2,
    REG_REPAIR_PADDING   = 3'd3,
    REG_TRANSITION_COUNT = 3'd4,
    REG_DESIGN_THICKNESS = 3'd5,
    REG_SAFETY_FACTOR    = 3'd6,
    REG_MIN_THICKNESS    = 3'd7
  } reg_e;

  typedef enum logic [1:0] {
    RGN_DESIGN = 2'd0,
    RGN_REPAIR = 2'd1,
    RGN_LOWER  = 2'd2,
    RGN_UPPER  = 2'd3
  } region_e;

  typedef struct packed {
    logic [CountW-1:0] station_count;
    logic [IdxW-1:0]   repair_start;
    logic [IdxW-1:0]   repair_end;
    logic [IdxW-1:0]   repair_padding;
    logic [IdxW-1:0]   transition_count;
    logic [ThickW-1:0] design_thickness;
    logic [SafeW-1:0]  safety_factor;
    logic [ThickW-1:0] min_thickness;
  } cfg_t;

  typedef struct packed {
    logic [IdxW-1:0]   idx;
    err_e              err;
    region_e           region;
    logic              span_zero;
    logic [ThickW-1:0] repaired;
  } side_t;

endpackage

FILE: design/ttp_if.sv
interface ttp_in_if;
  import ttp_pkg::*;
  logic            valid;
  logic            ready;
  logic [IdxW-1:0] station_index;
  modport source (output valid, output station_index, input ready);
  modport sink (input valid, input station_index, output ready);
endinterface

interface ttp_out_if;
  import ttp_pkg::*;
  logic              valid;
  logic              ready;
  logic [IdxW-1:0]   station_echo;
  logic              valid_plan;
  logic [2:0]        error_code;
  logic [ThickW-1:0] thickness;
  modport source (output valid, output station_echo, output valid_plan, output error_code,
                  output thickness, input ready);
  modport sink (input valid, input station_echo, input valid_plan, input error_code,
                input thickness, output ready);
endinterface

FILE: design/tapered_thickness_profile_top.sv
// Tapered thickness profile: one station index word in, one thickness word out, every unstalled cycle.
// The pipeline takes a new index in every cycle it is not stalled; each index passes through
// three setup stages, a 16-stage taper divider that resolves two quotient bits per stage,
// and the output register. A stall at the output freezes the whole pipeline. The user must
// write the configuration registers through the plain write port only while no word is in
// flight; the block itself does not enforce this.
module tapered_thickness_profile_top import ttp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  ttp_in_if.sink             in_i,
  ttp_out_if.source          out_o
);

  cfg_t cfg;
  logic en;

  ttp_cfg u_cfg (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .cfg_o(cfg)
  );

  logic out_vld_q;
  assign en         = out_o.ready || !out_vld_q;
  assign in_i.ready = en;

  // Stage 1: checks, range bounds, band classification, scaling product.
  err_e                 err1_d;
  region_e              rgn1_d;
  logic signed [PosW-1:0] last, rlo, rhi, tlo, thi, pos, k1, span1;

  always_comb begin
    if (cfg.station_count == '0 || 32'(cfg.station_count) > MaxStations) begin
      err1_d = ERR_COUNT;
    end else if (cfg.repair_end < cfg.repair_start ||
                 {1'b0, cfg.repair_end} >= cfg.station_count) begin
      err1_d = ERR_RANGE;
    end else if (cfg.design_thickness == '0) begin
      err1_d = ERR_DESIGN;
    end else if (cfg.safety_factor == '0 || cfg.safety_factor > SafetyOne) begin
      err1_d = ERR_SAFETY;
    end else if (cfg.min_thickness > cfg.design_thickness) begin
      err1_d = ERR_MIN;
    end else if ({1'b0, in_i.station_index} >= cfg.station_count) begin
      err1_d = ERR_INDEX;
    end else begin
      err1_d = ERR_OK;
    end
  end

  always_comb begin
    last = $signed(PosW'(cfg.station_count)) - PosW'(1);
    pos  = $signed(PosW'(in_i.station_index));
    rlo  = $signed(PosW'(cfg.repair_start)) - $signed(PosW'(cfg.repair_padding));
    if (rlo < 0) rlo = '0;
    rhi  = $signed(PosW'(cfg.repair_end)) + $signed(PosW'(cfg.repair_padding));
    if (rhi > last) rhi = last;
    tlo  = rlo - $signed(PosW'(cfg.transition_count));
    if (tlo < 0) tlo = '0;
    thi  = rhi + $signed(PosW'(cfg.transition_count));
    if (thi > last) thi = last;
    k1    = '0;
    span1 = '0;
    if (pos < tlo || pos > thi) begin
      rgn1_d = RGN_DESIGN;
    end else if (pos >= rlo && pos <= rhi) begin
      rgn1_d = RGN_REPAIR;
    end else if (pos < rlo) begin
      rgn1_d = RGN_LOWER;
      k1     = pos - tlo;
      span1  = rlo - tlo;
    end else begin
      rgn1_d = RGN_UPPER;
      k1     = pos - rhi;
      span1  = thi - rhi;
    end
  end

  logic                      vld1_q, vld2_q, vld3_q;
  logic [IdxW-1:0]           idx1_q, idx2_q, idx3_q;
  err_e                      err1_q, err2_q, err3_q;
  region_e                   rgn1_q, rgn2_q, rgn3_q;
  logic [IdxW-1:0]           k1_q, k2_q, span1_q, span2_q, span3_q;
  logic [ThickW+SafeW-1:0]   prod1_q;
  logic [ThickW-1:0]         rep2_q, mag2_q, rep3_q;
  logic [DivNumW-1:0]        num3_q;
  logic [ThickW-1:0]         scaled, rep2_d;

  // Stage 2: repaired value and its distance from the design value.
  assign scaled = prod1_q[ThickW+15:16];
  assign rep2_d = (cfg.min_thickness > scaled) ? cfg.min_thickness : scaled;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else if (en) begin
      vld1_q <= in_i.valid;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      idx1_q  <= in_i.station_index;
      err1_q  <= err1_d;
      rgn1_q  <= rgn1_d;
      k1_q    <= k1[IdxW-1:0];
      span1_q <= span1[IdxW-1:0];
      prod1_q <= cfg.design_thickness * cfg.safety_factor;

      idx2_q  <= idx1_q;
      err2_q  <= err1_q;
      rgn2_q  <= rgn1_q;
      k2_q    <= k1_q;
      span2_q <= span1_q;
      rep2_q  <= rep2_d;
      mag2_q  <= cfg.design_thickness - rep2_d;

      // Stage 3: taper numerator.
      idx3_q  <= idx2_q;
      err3_q  <= err2_q;
      rgn3_q  <= rgn2_q;
      span3_q <= span2_q;
      rep3_q  <= rep2_q;
      num3_q  <= mag2_q * k2_q;
    end
  end

  side_t             side3, side_div;
  logic              vld_div;
  logic [ThickW-1:0] quot;

  assign side3.idx       = idx3_q;
  assign side3.err       = err3_q;
  assign side3.region    = rgn3_q;
  assign side3.span_zero = (span3_q == '0);
  assign side3.repaired  = rep3_q;

  ttp_div u_div (
    .clk_i, .rst_ni, .en_i(en), .vld_i(vld3_q), .dividend_i(num3_q),
    .divisor_i(span3_q), .side_i(side3), .vld_o(vld_div), .quot_o(quot),
    .side_o(side_div)
  );

  // Output stage: the quotient is a magnitude; the lower band steps down
  // from the design value, the upper band steps up from the repaired value.
  logic [ThickW-1:0] thick_d, thick_q;
  logic [IdxW-1:0]   echo_q;
  err_e              err_q;

  always_comb begin
    thick_d = '0;
    if (side_div.err == ERR_OK) begin
      unique case (side_div.region)
        RGN_DESIGN: thick_d = cfg.design_thickness;
        RGN_REPAIR: thick_d = side_div.repaired;
        RGN_LOWER:  thick_d = side_div.span_zero ? side_div.repaired
                                                 : cfg.design_thickness - quot;
        RGN_UPPER:  thick_d = side_div.span_zero ? side_div.repaired
                                                 : side_div.repaired + quot;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vld_div;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      thick_q <= thick_d;
      echo_q  <= side_div.idx;
      err_q   <= side_div.err;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.station_echo = echo_q;
  assign out_o.valid_plan   = (err_q == ERR_OK);
  assign out_o.error_code   = err_q;
  assign out_o.thickness    = thick_q;

  a_zero_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.error_code != ERR_OK |-> out_o.thickness == '0)
    else $error("nonzero thickness on error");

  a_ok_within_design: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.valid_plan |-> out_o.thickness <= cfg.design_thickness)
    else $error("thickness above design value");

  a_ok_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.valid_plan |-> {1'b0, out_o.station_echo} < cfg.station_count)
    else $error("accepted station beyond count");

endmodule

FILE: design/ttp_cfg.sv
module ttp_cfg import ttp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (reg_e'(cfg_idx_i))
        REG_STATION_COUNT:    cfg_d.station_count    = cfg_data_i[CountW-1:0];
        REG_REPAIR_START:     cfg_d.repair_start     = cfg_data_i[IdxW-1:0];
        REG_REPAIR_END:       cfg_d.repair_end       = cfg_data_i[IdxW-1:0];
        REG_REPAIR_PADDING:   cfg_d.repair_padding   = cfg_data_i[IdxW-1:0];
        REG_TRANSITION_COUNT: cfg_d.transition_count = cfg_data_i[IdxW-1:0];
        REG_DESIGN_THICKNESS: cfg_d.design_thickness = cfg_data_i[ThickW-1:0];
        REG_SAFETY_FACTOR:    cfg_d.safety_factor    = cfg_data_i[SafeW-1:0];
        REG_MIN_THICKNESS:    cfg_d.min_thickness    = cfg_data_i[ThickW-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.station_count    <= CountW'(1);
      cfg_q.repair_start     <= '0;
      cfg_q.repair_end       <= '0;
      cfg_q.repair_padding   <= '0;
      cfg_q.transition_count <= '0;
      cfg_q.design_thickness <= ThickW'(65536);
      cfg_q.safety_factor    <= SafetyOne;
      cfg_q.min_thickness    <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: design/ttp_div.sv
module ttp_div import ttp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  logic [DivNumW-1:0] dividend_i,
  input  logic [IdxW-1:0]    divisor_i,
  input  side_t              side_i,
  output logic               vld_o,
  output logic [ThickW-1:0]  quot_o,
  output side_t              side_o
);

  // The quotient is known to fit in ThickW bits, so the upper dividend bits
  // start out as the partial remainder and never reach the divisor.
  logic              vld_q  [DivStages+1];
  logic [IdxW-1:0]   rem_q  [DivStages+1];
  logic [ThickW-1:0] num_q  [DivStages+1];
  logic [ThickW-1:0] quo_q  [DivStages+1];
  logic [IdxW-1:0]   dvs_q  [DivStages+1];
  side_t             side_q [DivStages+1];

  assign vld_q[0]  = vld_i;
  assign rem_q[0]  = dividend_i[DivNumW-1:ThickW];
  assign num_q[0]  = dividend_i[ThickW-1:0];
  assign quo_q[0]  = '0;
  assign dvs_q[0]  = divisor_i;
  assign side_q[0] = side_i;

  for (genvar s = 0; s < DivStages; s++) begin : g_stage
    logic [IdxW-1:0]   rem_d;
    logic [ThickW-1:0] quo_d;

    always_comb begin
      logic [IdxW:0] trial;
      rem_d = rem_q[s];
      quo_d = quo_q[s];
      for (int b = 0; b < DivBitsPerStage; b++) begin
        trial = {rem_d, num_q[s][ThickW-1-s*DivBitsPerStage-b]};
        if (trial >= {1'b0, dvs_q[s]}) begin
          trial = trial - {1'b0, dvs_q[s]};
          quo_d = {quo_d[ThickW-2:0], 1'b1};
        end else begin
          quo_d = {quo_d[ThickW-2:0], 1'b0};
        end
        rem_d = trial[IdxW-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1]  <= rem_d;
        num_q[s+1]  <= num_q[s];
        quo_q[s+1]  <= quo_d;
        dvs_q[s+1]  <= dvs_q[s];
        side_q[s+1] <= side_q[s];
      end
    end
  end

  assign vld_o  = vld_q[DivStages];
  assign quot_o = quo_q[DivStages];
  assign side_o = side_q[DivStages];

endmodule
